FILE: design/qse_pkg.sv
package qse_pkg;
    localparam int MaxSegmentsDefault = 8;
    localparam int Coefs = 6;
    localparam int WideW = 64;

    typedef enum logic [1:0] {
        OP_LOAD_COEF = 2'd0,
        OP_LOAD_TIME = 2'd1,
        OP_EVAL      = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_SAT = 2'd1;
    localparam logic [1:0] STATUS_ZERO_DUR = 2'd2;

    localparam logic signed [WideW-1:0] WideLim = 64'sd70368744177664;

    // Clamp a wide signed value to +-2^46.
    function automatic logic signed [WideW-1:0] clamp46(input logic signed [WideW-1:0] v);
        logic signed [WideW-1:0] r;
        r = v;
        if (v > WideLim) r = WideLim;
        if (v < -WideLim) r = -WideLim;
        return r;
    endfunction
endpackage

FILE: design/qse_ram.sv
module qse_ram #(
    parameter int Width = 32,
    parameter int Depth = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/quintic_spline_evaluator_core.sv
// Piecewise quintic spline evaluator. Load transactions (operation 0 and 1) write one
// coefficient, or one segment's start time and duration. In an evaluate transaction, seven
// bit-serial divisions take most of the time: tau, then one, two and three divisions by the
// duration for velocity, acceleration and jerk. The rest is 14 Horner steps, each product
// built from four 32x32 partial products, plus a seed step per polynomial, the segment
// search, which reads the start times one by one up to the active segment count, the
// coefficient fetch and sequencing. If a result is still waiting on m_ready when the next
// one is ready, the block stalls until the first result leaves. All tables live in memories
// with registered reads, and their content is undefined until loaded.
module quintic_spline_evaluator_core
    import qse_pkg::*;
#(
    parameter int MaxSegments = MaxSegmentsDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [2:0]         s_segment_index,
    input  logic [2:0]         s_coef_index,
    input  logic signed [31:0] s_coef_value,
    input  logic signed [31:0] s_start_time,
    input  logic [30:0]        s_duration,
    input  logic signed [31:0] s_eval_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_position,
    output logic signed [31:0] m_velocity,
    output logic signed [31:0] m_acceleration,
    output logic signed [31:0] m_jerk,
    output logic [2:0]         m_chosen_segment,
    output logic [1:0]         m_status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data
);
    localparam int SegW = $clog2(MaxSegments);
    localparam int CoefDepth = Coefs * MaxSegments;
    localparam int CoefAW = $clog2(CoefDepth);
    localparam int CntW = $clog2(MaxSegments + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SRCH, ST_SRCH_W, ST_DURRD, ST_DURW, ST_DIV,
        ST_CRD, ST_CRW, ST_HORN, ST_SCALE, ST_OUT
    } state_t;

    state_t state_reg;
    logic [3:0] seg_cfg_reg;
    logic [1:0] op_reg;
    logic [2:0] segi_reg, ci_reg;
    logic signed [31:0] cval_reg, start_reg, t_reg;
    logic [30:0] durin_reg;

    // Memories: coefficients, start times, durations.
    logic coef_we, tim_we;
    logic [CoefAW-1:0] coef_waddr, coef_raddr;
    logic [SegW-1:0] tim_waddr, tim_raddr;
    logic [31:0] coef_rdata, start_rdata;
    logic [30:0] dur_rdata;

    qse_ram #(.Width(32), .Depth(CoefDepth)) u_coef (
        .aclk(aclk), .we(coef_we), .waddr(coef_waddr), .wdata(cval_reg),
        .raddr(coef_raddr), .rdata(coef_rdata));
    qse_ram #(.Width(32), .Depth(MaxSegments)) u_start (
        .aclk(aclk), .we(tim_we), .waddr(tim_waddr), .wdata(start_reg),
        .raddr(tim_raddr), .rdata(start_rdata));
    qse_ram #(.Width(31), .Depth(MaxSegments)) u_dur (
        .aclk(aclk), .we(tim_we), .waddr(tim_waddr), .wdata(durin_reg),
        .raddr(tim_raddr), .rdata(dur_rdata));

    // Working registers.
    logic [CntW-1:0] n_reg, k_reg;
    logic [SegW-1:0] idx_reg;
    logic [30:0] dur_reg;
    logic [2:0] cnt_reg;
    logic signed [WideW-1:0] c_reg [Coefs];
    logic signed [WideW-1:0] tau_reg;
    logic signed [WideW-1:0] val_reg [4];
    logic [1:0] hsel_reg;
    logic [2:0] hstep_reg;
    logic [2:0] mstep_reg;    // partial product being accumulated
    logic [127:0] macc_reg;   // accumulated magnitude product
    logic [1:0] dsel_reg;     // which value is being divided
    logic [1:0] dleft_reg;    // remaining divisions for that value
    logic [1:0] dphase_reg;   // 0 tau, 1 scaling
    logic [6:0] dbit_reg;
    logic [62:0] dsh_reg;
    logic [62:0] drem_reg;
    logic [62:0] dq_reg;
    logic dneg_reg;

    // Horner step: product on magnitudes from four partial products, clamp, add.
    logic signed [WideW-1:0] hacc, hk, prod_s, sum_s;
    logic [WideW-1:0] ua, ub, pm;
    logic [31:0] mop_a, mop_b;
    logic [63:0] mpart;
    logic [127:0] mterm;
    logic signed [WideW-1:0] mult;
    always_comb begin
        hacc = val_reg[hsel_reg];
        unique case (hsel_reg)
            2'd0: hk = c_reg[hstep_reg];
            2'd1: hk = (hstep_reg == 3'd1) ? c_reg[1] * 64'sd4 :
                       (hstep_reg == 3'd2) ? c_reg[2] * 64'sd3 :
                       (hstep_reg == 3'd3) ? c_reg[3] * 64'sd2 : c_reg[4];
            2'd2: hk = (hstep_reg == 3'd1) ? c_reg[1] * 64'sd12 :
                       (hstep_reg == 3'd2) ? c_reg[2] * 64'sd6 : c_reg[3] * 64'sd2;
            default: hk = (hstep_reg == 3'd1) ? c_reg[1] * 64'sd24 : c_reg[2] * 64'sd6;
        endcase
        ua = hacc[WideW-1] ? 64'(-hacc) : 64'(hacc);
        ub = tau_reg[WideW-1] ? 64'(-tau_reg) : 64'(tau_reg);
        mop_a = mstep_reg[1] ? ua[63:32] : ua[31:0];
        mop_b = mstep_reg[0] ? ub[63:32] : ub[31:0];
        mpart = mop_a * mop_b;
        unique case (mstep_reg[1:0])
            2'd0: mterm = {64'd0, mpart};
            2'd3: mterm = {mpart, 64'd0};
            default: mterm = {32'd0, mpart, 32'd0};
        endcase
        if (macc_reg[127:62] != '0) pm = 64'(WideLim);
        else pm = macc_reg[79:16];
        if (pm > 64'(WideLim)) pm = 64'(WideLim);
        prod_s = (hacc[WideW-1] != tau_reg[WideW-1]) ? -$signed(pm) : $signed(pm);
        sum_s = clamp46(prod_s + hk);
        mult = 64'sd0;
        unique case (hsel_reg)
            2'd1: mult = c_reg[0] * 64'sd5;
            2'd2: mult = c_reg[0] * 64'sd20;
            2'd3: mult = c_reg[0] * 64'sd60;
            default: mult = c_reg[0];
        endcase
    end

    // Horner step count per polynomial: 5, 4, 3, 2.
    logic [2:0] hlast;
    assign hlast = 3'(5 - 32'(hsel_reg));

    // Divider trial subtraction.
    logic [62:0] rtrial;
    logic dfit;
    always_comb begin
        rtrial = {drem_reg[61:0], dsh_reg[62]};
        dfit = rtrial >= 63'(dur_reg);
    end

    logic signed [31:0] sat32 [4];
    logic [3:0] satf;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            satf[i] = 1'b0;
            sat32[i] = val_reg[i][31:0];
            if (val_reg[i] > 64'sd2147483647) begin
                sat32[i] = 32'sh7fffffff; satf[i] = 1'b1;
            end else if (val_reg[i] < -64'sd2147483648) begin
                sat32[i] = 32'sh80000000; satf[i] = 1'b1;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign coef_we = (state_reg == ST_LOAD) && (op_reg == OP_LOAD_COEF) && (ci_reg < 3'd6)
                     && (32'(segi_reg) < MaxSegments);
    assign tim_we = (state_reg == ST_LOAD) && (op_reg == OP_LOAD_TIME)
                    && (32'(segi_reg) < MaxSegments);
    assign coef_waddr = CoefAW'(32'(segi_reg) * Coefs + 32'(ci_reg));
    assign tim_waddr = SegW'(segi_reg);
    assign coef_raddr = CoefAW'(32'(idx_reg) * Coefs + 32'(cnt_reg));
    assign tim_raddr = (state_reg == ST_SRCH || state_reg == ST_SRCH_W) ?
                       SegW'(k_reg) : idx_reg;

    // A result register is loaded when a result is ready and the register is free.
    logic out_load;
    assign out_load = (!m_valid || m_ready) &&
                      ((state_reg == ST_OUT) || (state_reg == ST_DURW && dur_rdata == '0));

    logic [62:0] dmag;
    always_comb begin
        dmag = {val_reg[dsel_reg][WideW-1] ? 47'(-val_reg[dsel_reg]) : 47'(val_reg[dsel_reg]),
                16'd0};
    end

    // Control and datapath sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seg_cfg_reg <= 4'd1;
            m_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) seg_cfg_reg <= cfg_data;
            if (out_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg <= s_operation;
                        segi_reg <= s_segment_index;
                        ci_reg <= s_coef_index;
                        cval_reg <= s_coef_value;
                        start_reg <= s_start_time;
                        durin_reg <= s_duration;
                        t_reg <= s_eval_time;
                        idx_reg <= '0;
                        k_reg <= CntW'(1);
                        if (seg_cfg_reg == 4'd0) n_reg <= CntW'(1);
                        else if (32'(seg_cfg_reg) > MaxSegments) n_reg <= CntW'(MaxSegments);
                        else n_reg <= CntW'(seg_cfg_reg);
                        if (s_operation == OP_EVAL) state_reg <= ST_SRCH;
                        else state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: state_reg <= ST_IDLE;
                ST_SRCH: begin
                    if (k_reg >= n_reg) state_reg <= ST_DURRD;
                    else state_reg <= ST_SRCH_W;
                end
                ST_SRCH_W: begin
                    if ($signed(start_rdata) < t_reg) idx_reg <= idx_reg + 1'b1;
                    k_reg <= k_reg + 1'b1;
                    state_reg <= ST_SRCH;
                end
                ST_DURRD: state_reg <= ST_DURW;
                ST_DURW: begin
                    dur_reg <= dur_rdata;
                    if (dur_rdata == '0) begin
                        if (!m_valid || m_ready) begin
                            m_position <= '0; m_velocity <= '0;
                            m_acceleration <= '0; m_jerk <= '0;
                            m_chosen_segment <= 3'(idx_reg);
                            m_status <= STATUS_ZERO_DUR;
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        val_reg[0] <= 64'(t_reg) - 64'($signed(start_rdata));
                        dsel_reg <= 2'd0;
                        dphase_reg <= 2'd0;
                        dleft_reg <= 2'd1;
                        dbit_reg <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (dbit_reg == 7'd0) begin
                        dsh_reg <= dmag;
                        drem_reg <= '0;
                        dq_reg <= '0;
                        dneg_reg <= val_reg[dsel_reg][WideW-1];
                        dbit_reg <= 7'd1;
                    end else if (dbit_reg <= 7'd63) begin
                        dsh_reg <= {dsh_reg[61:0], 1'b0};
                        drem_reg <= dfit ? rtrial - 63'(dur_reg) : rtrial;
                        dq_reg <= {dq_reg[61:0], dfit};
                        dbit_reg <= dbit_reg + 1'b1;
                    end else begin
                        dbit_reg <= '0;
                        if (dphase_reg == 2'd0) begin
                            tau_reg <= dneg_reg ? -$signed({1'b0, dq_reg}) :
                                                   $signed({1'b0, dq_reg});
                            cnt_reg <= '0;
                            state_reg <= ST_CRD;
                        end else begin
                            val_reg[dsel_reg] <= dneg_reg ?
                                -clamp46($signed({1'b0, dq_reg})) :
                                clamp46($signed({1'b0, dq_reg}));
                            if (dleft_reg > 2'd1) dleft_reg <= dleft_reg - 1'b1;
                            else if (dsel_reg == 2'd3) state_reg <= ST_OUT;
                            else begin
                                // The next value needs one division per duration power.
                                dsel_reg <= dsel_reg + 1'b1;
                                dleft_reg <= dsel_reg + 2'd1;
                            end
                        end
                    end
                end
                ST_CRD: state_reg <= ST_CRW;
                ST_CRW: begin
                    c_reg[cnt_reg] <= 64'($signed(coef_rdata));
                    if (cnt_reg == 3'd5) begin
                        hsel_reg <= 2'd0;
                        hstep_reg <= 3'd0;
                        state_reg <= ST_HORN;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= ST_CRD;
                    end
                end
                ST_HORN: begin
                    if (hstep_reg == 3'd0) begin
                        val_reg[hsel_reg] <= mult;
                        hstep_reg <= 3'd1;
                        mstep_reg <= '0;
                        macc_reg <= '0;
                    end else if (mstep_reg != 3'd4) begin
                        // The partial products of one step are accumulated one at a time.
                        macc_reg <= macc_reg + mterm;
                        mstep_reg <= mstep_reg + 1'b1;
                    end else begin
                        val_reg[hsel_reg] <= sum_s;
                        mstep_reg <= '0;
                        macc_reg <= '0;
                        if (hstep_reg == hlast) begin
                            hstep_reg <= 3'd0;
                            if (hsel_reg == 2'd3) state_reg <= ST_SCALE;
                            else hsel_reg <= hsel_reg + 1'b1;
                        end else hstep_reg <= hstep_reg + 1'b1;
                    end
                end
                ST_SCALE: begin
                    dsel_reg <= 2'd1;
                    dleft_reg <= 2'd1;
                    dphase_reg <= 2'd1;
                    dbit_reg <= '0;
                    state_reg <= ST_DIV;
                end
                ST_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_position <= sat32[0];
                        m_velocity <= sat32[1];
                        m_acceleration <= sat32[2];
                        m_jerk <= sat32[3];
                        m_chosen_segment <= 3'(idx_reg);
                        m_status <= (satf != '0) ? STATUS_SAT : STATUS_OK;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // The segment search never passes the active segment count.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRCH) |-> (CntW'(idx_reg) < n_reg))
        else $error("segment index beyond active count");
    // A result is only raised from the output or zero-duration states.
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_OUT || $past(state_reg) == ST_DURW))
        else $error("result raised from wrong state");
    // Memory writes happen only in the load state.
    a_we: assert property (@(posedge aclk) disable iff (!aresetn)
        (coef_we || tim_we) |-> (state_reg == ST_LOAD))
        else $error("table write outside load");
endmodule
